FILE: sv/etc_pkg.sv
package etc_pkg;

  localparam int unsigned BUFFER_BYTES = 32;
  localparam int unsigned MAX_RESULTS  = 64;
  localparam int unsigned QUEUE_DEPTH  = 2;

  localparam logic [17:0] BLOCK_LIMIT    = 18'h0FFFF;
  localparam logic [6:0]  BLOCK_BIT      = 7'b0000100;
  localparam logic [17:0] ONE_BYTE_LIMIT = 18'd2048;

  localparam logic [1:0] CFG_DEVICE_ADDRESS = 2'd0;
  localparam logic [1:0] CFG_MEMORY_SIZE    = 2'd1;
  localparam logic [1:0] CFG_PAGE_SIZE      = 2'd2;

  typedef struct packed {
    logic [6:0]  device_address;
    logic [17:0] memory_size;
    logic [7:0]  page_size;
  } cfg_t;

  // one classified request handed from front to back
  typedef struct packed {
    logic        is_write;
    logic        clipped;
    logic        multi_block;
    logic        two_bytes;
    logic [6:0]  device_address;
    logic [16:0] address;
    logic [8:0]  remaining;
    logic [8:0]  max_chunk;
    logic [8:0]  page;
    logic [7:0]  page_pos;
  } desc_t;

  typedef struct packed {
    logic valid;
    logic full;
  } queue_status_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_PUSH
  } front_state_e;

  typedef enum logic {
    B_IDLE,
    B_RUN
  } back_state_e;

endpackage

FILE: sv/etc_front.sv
module etc_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  etc_pkg::cfg_t           cfg_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    mode_i,
  input  logic [16:0]             start_address_i,
  input  logic [8:0]              byte_count_i,
  input  etc_pkg::queue_status_t  queue_status_i,
  output logic                    push_o,
  output etc_pkg::desc_t          desc_o
);
  import etc_pkg::*;

  front_state_e state_q, state_d;
  desc_t        desc_q;
  logic [16:0]  div_sh_q;
  logic [4:0]   div_cnt_q;
  logic [7:0]   div_rem_q;

  logic        accept;
  logic [17:0] end_sum;
  logic        clip;
  logic [8:0]  clip_rem;
  logic [8:0]  remaining;
  logic [8:0]  page9;
  logic [8:0]  max_chunk;
  logic [8:0]  rem_shift;
  logic [8:0]  rem_sub;
  logic        div_done;

  assign accept = in_valid_i && in_ready_o;

  always_comb begin
    end_sum  = {1'b0, start_address_i} + {9'd0, byte_count_i};
    clip     = mode_i && (end_sum > cfg_i.memory_size);
    clip_rem = 9'd0;
    if ({1'b0, start_address_i} < cfg_i.memory_size) begin
      clip_rem = 9'(cfg_i.memory_size - {1'b0, start_address_i});
    end
    remaining = clip ? clip_rem : byte_count_i;
    page9     = (cfg_i.page_size == 8'd0) ? 9'd256 : {1'b0, cfg_i.page_size};
    max_chunk = 9'(BUFFER_BYTES);
    if (mode_i && (page9 < max_chunk)) begin
      max_chunk = page9;
    end
  end

  // restoring division step for start_address % page
  always_comb begin
    rem_shift = {div_rem_q, div_sh_q[16]};
    rem_sub   = rem_shift - desc_q.page;
  end

  assign div_done = (div_cnt_q == 5'd16);

  always_comb begin
    state_d = state_q;
    case (state_q)
      F_IDLE: begin
        if (accept && (remaining != 9'd0)) begin
          state_d = mode_i ? F_DIV : F_PUSH;
        end
      end
      F_DIV: begin
        if (div_done) begin
          state_d = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!queue_status_i.full) begin
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    push_o     = 1'b0;
    case (state_q)
      F_IDLE:  in_ready_o = 1'b1;
      F_DIV:   push_o     = 1'b0;
      F_PUSH:  push_o     = !queue_status_i.full;
      default: push_o     = 1'b0;
    endcase
  end

  assign desc_o = desc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      desc_q.is_write       <= mode_i;
      desc_q.clipped        <= clip;
      desc_q.multi_block    <= cfg_i.memory_size > BLOCK_LIMIT;
      desc_q.two_bytes      <= cfg_i.memory_size > ONE_BYTE_LIMIT;
      desc_q.device_address <= cfg_i.device_address;
      desc_q.address        <= start_address_i;
      desc_q.remaining      <= remaining;
      desc_q.max_chunk      <= max_chunk;
      desc_q.page           <= page9;
      desc_q.page_pos       <= 8'd0;
      div_sh_q              <= start_address_i;
      div_cnt_q             <= 5'd0;
      div_rem_q             <= 8'd0;
    end else if (state_q == F_DIV) begin
      div_sh_q  <= {div_sh_q[15:0], 1'b0};
      div_cnt_q <= div_cnt_q + 5'd1;
      if (rem_shift >= desc_q.page) begin
        div_rem_q <= rem_sub[7:0];
      end else begin
        div_rem_q <= rem_shift[7:0];
      end
      if (div_done) begin
        desc_q.page_pos <= (rem_shift >= desc_q.page) ? rem_sub[7:0] : rem_shift[7:0];
      end
    end
  end

endmodule

FILE: sv/etc_queue.sv
module etc_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  etc_pkg::desc_t         push_data_i,
  input  logic                   pop_i,
  output etc_pkg::desc_t         pop_data_o,
  output etc_pkg::queue_status_t status_o
);
  import etc_pkg::*;

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);

  desc_t             mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0]   wptr_q, rptr_q;
  logic [PtrW:0]     count_q;

  assign status_o.valid = (count_q != '0);
  assign status_o.full  = (count_q == (PtrW+1)'(QUEUE_DEPTH));
  assign pop_data_o     = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + PtrW'(1);
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + (PtrW+1)'(1);
        2'b01:   count_q <= count_q - (PtrW+1)'(1);
        default: count_q <= count_q;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_o.full && !pop_i |-> !push_i)
    else $error("push into full queue");

endmodule

FILE: sv/etc_back.sv
module etc_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  etc_pkg::queue_status_t queue_status_i,
  input  etc_pkg::desc_t         desc_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [16:0]            chunk_address_o,
  output logic [8:0]             chunk_offset_o,
  output logic [7:0]             chunk_length_o,
  output logic [6:0]             bus_address_o,
  output logic                   two_address_bytes_o,
  output logic                   is_write_o,
  output logic                   clipped_o,
  output logic                   last_o
);
  import etc_pkg::*;

  back_state_e state_q, state_d;
  desc_t       d_q;
  logic [16:0] addr_q;
  logic [8:0]  rem_q;
  logic [8:0]  off_q;
  logic [7:0]  pos_q;
  logic [5:0]  n_q;

  logic        out_valid_q;
  logic [16:0] chunk_address_q;
  logic [8:0]  chunk_offset_q;
  logic [7:0]  chunk_length_q;
  logic [6:0]  bus_address_q;
  logic        two_address_bytes_q;
  logic        is_write_q;
  logic        clipped_q;
  logic        last_q;

  logic        slot_free;
  logic        emit;
  logic [8:0]  amt_buf, room_pg, amt_pg, amt;
  logic [16:0] room_blk;
  logic [8:0]  rem_next;
  logic        last_c;
  logic [8:0]  pos_sum;
  logic [17:0] addr_sum;
  logic [6:0]  bus_c;

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    amt_buf  = (rem_q < d_q.max_chunk) ? rem_q : d_q.max_chunk;
    room_pg  = d_q.page - {1'b0, pos_q};
    amt_pg   = (d_q.is_write && (room_pg < amt_buf)) ? room_pg : amt_buf;
    room_blk = 17'h10000 - {1'b0, addr_q[15:0]};
    amt      = (d_q.multi_block && (room_blk < {8'd0, amt_pg})) ? room_blk[8:0] : amt_pg;
    rem_next = rem_q - amt;
    last_c   = (rem_next == 9'd0) || (n_q == 6'(MAX_RESULTS - 1));
    pos_sum  = {1'b0, pos_q} + amt;
    addr_sum = {1'b0, addr_q} + {9'd0, amt};
    bus_c    = d_q.device_address | ((d_q.multi_block && addr_q[16]) ? BLOCK_BIT : 7'd0);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE: begin
        if (queue_status_i.valid) begin
          state_d = B_RUN;
        end
      end
      B_RUN: begin
        if (slot_free && last_c) begin
          state_d = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_comb begin
    pop_o = 1'b0;
    emit  = 1'b0;
    case (state_q)
      B_IDLE:  pop_o = queue_status_i.valid;
      B_RUN:   emit  = slot_free;
      default: emit  = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      d_q    <= desc_i;
      addr_q <= desc_i.address;
      rem_q  <= desc_i.remaining;
      off_q  <= 9'd0;
      pos_q  <= desc_i.page_pos;
      n_q    <= 6'd0;
    end else if (emit) begin
      addr_q <= addr_sum[16:0];
      rem_q  <= rem_next;
      off_q  <= off_q + amt;
      // wrapping to address zero restarts the page
      pos_q  <= (addr_sum[17] || (pos_sum == d_q.page)) ? 8'd0 : pos_sum[7:0];
      n_q    <= n_q + 6'd1;
    end
    if (emit) begin
      chunk_address_q     <= addr_q;
      chunk_offset_q      <= off_q;
      chunk_length_q      <= amt[7:0];
      bus_address_q       <= bus_c;
      two_address_bytes_q <= d_q.two_bytes;
      is_write_q          <= d_q.is_write;
      clipped_q           <= d_q.clipped;
      last_q              <= last_c;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign chunk_address_o     = chunk_address_q;
  assign chunk_offset_o      = chunk_offset_q;
  assign chunk_length_o      = chunk_length_q;
  assign bus_address_o       = bus_address_q;
  assign two_address_bytes_o = two_address_bytes_q;
  assign is_write_o          = is_write_q;
  assign clipped_o           = clipped_q;
  assign last_o              = last_q;

  a_nonzero_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> (amt != 9'd0) && (amt <= d_q.max_chunk))
    else $error("transfer length out of range");

  a_last_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && last_c |=> state_q == B_IDLE)
    else $error("request not closed after last transfer");

  a_page_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && d_q.is_write |-> pos_sum <= d_q.page)
    else $error("write crosses a page line");

endmodule

FILE: sv/eeprom_transfer_chunker_top.sv
// Serial EEPROM transfer chunker.
// Input channel (in_valid_i/in_ready_o) takes one read or write request:
// mode, start address and byte count. Output channel (out_valid_o/
// out_ready_i) gives one transaction per bus transfer, the last one marked.
// Configuration registers (device address, memory size, page size) are
// written through cfg_we_i/cfg_index_i/cfg_wdata_i; the user must do so only
// while the block is idle, which the block itself does not enforce. The front
// classifies a request (clip check, page offset) and hands it on through a
// two-entry queue to the back, which emits the transfers. Front: a write
// passes the bit-serial page-offset division (one quotient bit per cycle
// over 17 address bits) before it is pushed; a read skips it. Back: one
// transfer per cycle while the receiver keeps out_ready_i high.
// A stalled receiver holds the output register; the back stops, the queue
// fills and the front then holds off new requests.
// Reset empties the queue, drops any request in progress and loads the
// register defaults: address 80, size 32768, page 64.
module eeprom_transfer_chunker_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [17:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        mode_i,
  input  logic [16:0] start_address_i,
  input  logic [8:0]  byte_count_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [16:0] chunk_address_o,
  output logic [8:0]  chunk_offset_o,
  output logic [7:0]  chunk_length_o,
  output logic [6:0]  bus_address_o,
  output logic        two_address_bytes_o,
  output logic        is_write_o,
  output logic        clipped_o,
  output logic        last_o
);
  import etc_pkg::*;

  cfg_t          cfg_q;
  logic          push, pop;
  desc_t         push_desc, pop_desc;
  queue_status_t queue_status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.device_address <= 7'd80;
      cfg_q.memory_size    <= 18'd32768;
      cfg_q.page_size      <= 8'd64;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_DEVICE_ADDRESS: cfg_q.device_address <= cfg_wdata_i[6:0];
        CFG_MEMORY_SIZE:    cfg_q.memory_size    <= cfg_wdata_i;
        CFG_PAGE_SIZE:      cfg_q.page_size      <= cfg_wdata_i[7:0];
        default:            cfg_q                <= cfg_q;
      endcase
    end
  end

  etc_front u_front (
    .clk_i,
    .rst_ni,
    .cfg_i          (cfg_q),
    .in_valid_i,
    .in_ready_o,
    .mode_i,
    .start_address_i,
    .byte_count_i,
    .queue_status_i (queue_status),
    .push_o         (push),
    .desc_o         (push_desc)
  );

  etc_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i      (push),
    .push_data_i (push_desc),
    .pop_i       (pop),
    .pop_data_o  (pop_desc),
    .status_o    (queue_status)
  );

  etc_back u_back (
    .clk_i,
    .rst_ni,
    .queue_status_i (queue_status),
    .desc_i         (pop_desc),
    .pop_o          (pop),
    .out_valid_o,
    .out_ready_i,
    .chunk_address_o,
    .chunk_offset_o,
    .chunk_length_o,
    .bus_address_o,
    .two_address_bytes_o,
    .is_write_o,
    .clipped_o,
    .last_o
  );

endmodule
